@@ rtl/deb_pkg.sv @@
// ----------------------------------------------------------------------------
// deb_pkg - shared types and constants for the double-ended ring buffer
// Opcode and status codes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package deb_pkg;

  localparam int CNT_W          = 9;   // count, capacity, position fields
  localparam int OP_W           = 3;
  localparam int ST_W           = 3;
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 8;
  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_ERASE      = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BADIDX  = 3'd3,
    ST_ZEROCAP = 3'd4
  } status_t;

endpackage

@@ rtl/deb_addr.sv @@
// ----------------------------------------------------------------------------
// deb_addr - ring address unit
// Maps a logical offset from the head to a slot: (base + offset) mod cap,
// valid while base < cap and offset < cap (one add, one compare-subtract).
// ----------------------------------------------------------------------------
module deb_addr (
  input  logic [deb_pkg::CNT_W-1:0] base,
  input  logic [deb_pkg::CNT_W-1:0] offset,
  input  logic [deb_pkg::CNT_W-1:0] cap,
  output logic [deb_pkg::CNT_W-1:0] phys
);

  localparam int CW = deb_pkg::CNT_W;

  logic [CW:0] sum;
  logic [CW:0] wrapped;

  assign sum     = {1'b0, base} + {1'b0, offset};
  assign wrapped = sum - {1'b0, cap};
  assign phys    = (sum >= {1'b0, cap}) ? wrapped[CW-1:0] : sum[CW-1:0];

endmodule

@@ rtl/deb_mem.sv @@
// ----------------------------------------------------------------------------
// deb_mem - slot storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module deb_mem #(
  parameter int DEPTH      = deb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deb_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/double_ended_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// double_ended_ring_buffer - deque on a circular store with run-time capacity
// Sequencer around one ring address unit and one slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with opcode, item_value, position,
//   range_end. A request is taken when in_valid is high and in_stall low.
//   Result channel: out_valid / out_stall with read_value, status,
//   element_count, is_full, is_empty; one result per request, in order.
//   Capacity port: cfg_valid / cfg_ready / cfg_data; a write sets the
//   capacity (saturated to DEPTH) and empties the buffer.
// Sequencing:
//   Push, pop, clear and any rejected request pass S_EXEC, then S_FINISH;
//   a good read adds S_RD_WAIT. Insert and erase add S_MV_RD and S_MV_WR
//   per element moved, and an insert ends in S_INS_WR (a full insert at
//   index 0 does nothing); each move is a RAM read then a RAM write through
//   the one address unit, so the single RAM port pair sets the pace.
//   One request is in work at a time; in_stall is high until it is done.
//   The result sits in an output register, so the next request is taken
//   while a result waits; under a held out_stall that next result parks in
//   S_FINISH and keeps in_stall high until the output register frees up.
// Reset (synchronous, rst high): buffer empty, capacity 256, no result.
//   Slot contents are not cleared; only stored elements are ever read.
// ----------------------------------------------------------------------------
module double_ended_ring_buffer #(
  parameter int DEPTH      = deb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deb_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // capacity write port
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [deb_pkg::CNT_W-1:0] cfg_data,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [deb_pkg::OP_W-1:0]  opcode,
  input  logic [DATA_WIDTH-1:0]     item_value,
  input  logic [deb_pkg::CNT_W-1:0] position,
  input  logic [deb_pkg::CNT_W-1:0] range_end,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [DATA_WIDTH-1:0]     read_value,
  output logic [deb_pkg::ST_W-1:0]  status,
  output logic [deb_pkg::CNT_W-1:0] element_count,
  output logic                      is_full,
  output logic                      is_empty
);

  localparam int CW      = deb_pkg::CNT_W;
  localparam int AW      = $clog2(DEPTH);
  // capacity field tops out at 511, so DEPTH only limits below that
  localparam int CAP_LIM = (DEPTH < 511) ? DEPTH : 511;
  localparam logic [CW-1:0] CAP_MAX = CW'(CAP_LIM);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,     // decode, checks, single-slot updates
    S_MV_RD,    // read source slot of a move
    S_MV_WR,    // write it to the destination slot
    S_INS_WR,   // drop the inserted item into its slot
    S_RD_WAIT,  // registered RAM read for a read request
    S_FINISH    // hand result to the output register
  } state_t;

  state_t           state;
  deb_pkg::op_t     op_r;
  logic [DATA_WIDTH-1:0] item_r;
  logic [CW-1:0]    pos_r;
  logic [CW-1:0]    rend_r;
  logic [CW-1:0]    cap_reg;
  logic [CW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    moves;     // moves still to do
  logic [CW-1:0]    src;       // logical source of the current move
  logic [CW-1:0]    dst;       // logical destination of the current move
  logic [CW-1:0]    fin;       // logical slot for the inserted item
  logic             dir_up;
  logic             ins_fin;   // a final insert write follows the moves
  deb_pkg::status_t st_r;
  logic [DATA_WIDTH-1:0] rd_r;

  logic [CW-1:0]         eff_cap;
  logic [CW-1:0]         au_off;
  logic [CW-1:0]         phys;
  logic                  is_push;
  logic                  push_ok;
  logic                  fin_go;
  deb_pkg::status_t      exec_st;
  state_t                exec_state;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign eff_cap   = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign is_push = (op_r == deb_pkg::OP_PUSH_BACK) || (op_r == deb_pkg::OP_PUSH_FRONT);
  assign push_ok = is_push && (eff_cap != '0) && (count < eff_cap);

  // result leaves for the output register once that register is free
  assign fin_go = (state == S_FINISH) && (!out_valid || !out_stall);

  // status and follow-on state decided in the exec cycle
  always_comb begin
    exec_st    = deb_pkg::ST_OK;
    exec_state = S_FINISH;
    unique case (op_r) inside
      deb_pkg::OP_PUSH_BACK, deb_pkg::OP_PUSH_FRONT: begin
        if (eff_cap == '0) begin
          exec_st = deb_pkg::ST_ZEROCAP;
        end else if (count >= eff_cap) begin
          exec_st = deb_pkg::ST_FULL;
        end
      end
      deb_pkg::OP_POP_BACK, deb_pkg::OP_POP_FRONT: begin
        if ((count == '0) || (eff_cap == '0)) begin
          exec_st = deb_pkg::ST_EMPTY;
        end
      end
      deb_pkg::OP_READ: begin
        if ((pos_r >= count) || (eff_cap == '0)) begin
          exec_st = deb_pkg::ST_BADIDX;
        end else begin
          exec_state = S_RD_WAIT;
        end
      end
      deb_pkg::OP_INSERT: begin
        if (eff_cap == '0) begin
          exec_st = deb_pkg::ST_ZEROCAP;
        end else if (pos_r > count) begin
          exec_st = deb_pkg::ST_BADIDX;
        end else if (count < eff_cap) begin
          exec_state = (count == pos_r) ? S_INS_WR : S_MV_RD;
        end else if (pos_r != '0) begin
          exec_state = (pos_r == CW'(1)) ? S_INS_WR : S_MV_RD;
        end
      end
      deb_pkg::OP_ERASE: begin
        if ((pos_r > rend_r) || (rend_r > count)) begin
          exec_st = deb_pkg::ST_BADIDX;
        end else if ((rend_r > pos_r) && (eff_cap != '0)) begin
          exec_state = (count == rend_r) ? S_FINISH : S_MV_RD;
        end
      end
      default: begin
        exec_st = deb_pkg::ST_OK;
      end
    endcase
  end

  // offset fed to the shared address unit, one use per cycle
  always_comb begin
    au_off = '0;
    unique case (state)
      S_EXEC: begin
        unique case (op_r)
          deb_pkg::OP_PUSH_BACK:  au_off = count;
          deb_pkg::OP_PUSH_FRONT: au_off = eff_cap - 1'b1;  // head - 1 mod cap
          deb_pkg::OP_POP_FRONT:  au_off = CW'(1);
          deb_pkg::OP_READ:       au_off = pos_r;
          default:                au_off = '0;
        endcase
      end
      S_MV_RD:  au_off = src;
      S_MV_WR:  au_off = dst;
      S_INS_WR: au_off = fin;
      default:  au_off = '0;
    endcase
  end

  deb_addr u_addr (
    .base   (head),
    .offset (au_off),
    .cap    (eff_cap),
    .phys   (phys)
  );

  assign mem_addr  = AW'(phys);
  assign mem_we    = ((state == S_EXEC) && push_ok) || (state == S_MV_WR) ||
                     (state == S_INS_WR);
  assign mem_wdata = (state == S_MV_WR) ? mem_rdata : item_r;

  deb_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_reg   <= deb_pkg::CAP_RESET;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= deb_pkg::op_t'(opcode);
            item_r <= item_value;
            pos_r  <= position;
            rend_r <= range_end;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          st_r  <= exec_st;
          rd_r  <= '0;
          state <= exec_state;
          unique case (op_r) inside
            deb_pkg::OP_PUSH_BACK, deb_pkg::OP_PUSH_FRONT: begin
              if (push_ok) begin
                // slot write happens this cycle at phys
                count <= count + 1'b1;
                if (op_r == deb_pkg::OP_PUSH_FRONT) begin
                  head <= phys;
                end
              end
            end
            deb_pkg::OP_POP_BACK, deb_pkg::OP_POP_FRONT: begin
              if ((count != '0) && (eff_cap != '0)) begin
                count <= count - 1'b1;
                if (op_r == deb_pkg::OP_POP_FRONT) begin
                  head <= phys;
                end
              end
            end
            deb_pkg::OP_READ: ;  // RAM read issued this cycle at phys
            deb_pkg::OP_INSERT: begin
              ins_fin <= 1'b1;
              if ((eff_cap != '0) && (pos_r <= count)) begin
                if (count < eff_cap) begin
                  // shift [pos, count) up by one, top down
                  count  <= count + 1'b1;
                  moves  <= count - pos_r;
                  dst    <= count;
                  src    <= count - 1'b1;
                  dir_up <= 1'b0;
                  fin    <= pos_r;
                end else if (pos_r != '0) begin
                  // full: drop front, shift [1, pos) down by one
                  moves  <= pos_r - 1'b1;
                  dst    <= '0;
                  src    <= CW'(1);
                  dir_up <= 1'b1;
                  fin    <= pos_r - 1'b1;
                end
              end
            end
            deb_pkg::OP_ERASE: begin
              ins_fin <= 1'b0;
              if ((pos_r <= rend_r) && (rend_r <= count) && (rend_r > pos_r) &&
                  (eff_cap != '0)) begin
                // close the gap: move [rend, count) down to pos
                count  <= count - (rend_r - pos_r);
                moves  <= count - rend_r;
                dst    <= pos_r;
                src    <= rend_r;
                dir_up <= 1'b1;
              end
            end
            default: begin
              count <= '0;
              head  <= '0;
            end
          endcase
        end

        S_MV_RD: begin
          state <= S_MV_WR;
        end

        S_MV_WR: begin
          moves <= moves - 1'b1;
          if (dir_up) begin
            src <= src + 1'b1;
            dst <= dst + 1'b1;
          end else begin
            src <= src - 1'b1;
            dst <= dst - 1'b1;
          end
          if (moves == CW'(1)) begin
            state <= ins_fin ? S_INS_WR : S_FINISH;
          end else begin
            state <= S_MV_RD;
          end
        end

        S_INS_WR: begin
          state <= S_FINISH;
        end

        S_RD_WAIT: begin
          rd_r  <= mem_rdata;
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (fin_go) begin
            read_value    <= rd_r;
            status        <= st_r;
            element_count <= count;
            is_full       <= (count == eff_cap);
            is_empty      <= (count == '0);
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase

      // capacity write empties the buffer
      if (cfg_valid && cfg_ready) begin
        cap_reg <= cfg_data;
        head    <= '0;
        count   <= '0;
      end
    end
  end

endmodule

@@ rtl/deb_checker.sv @@
// ----------------------------------------------------------------------------
// deb_checker - port-level checks for the double-ended ring buffer
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module deb_checker #(
  parameter int DATA_WIDTH = deb_pkg::DATA_WIDTH_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [DATA_WIDTH-1:0]     read_value,
  input logic [deb_pkg::ST_W-1:0]  status,
  input logic [deb_pkg::CNT_W-1:0] element_count,
  input logic                      is_full,
  input logic                      is_empty
);

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous still in work");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(element_count) && $stable(read_value)))
    else $error("stalled result changed");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (element_count == '0)))
    else $error("empty flag disagrees with count");

  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == deb_pkg::ST_FULL)) |-> is_full)
    else $error("full rejection without full flag");

  a_zerocap_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == deb_pkg::ST_ZEROCAP)) |-> (is_full && is_empty))
    else $error("zero capacity result with wrong flags");

endmodule

bind double_ended_ring_buffer deb_checker #(.DATA_WIDTH(DATA_WIDTH)) u_deb_checker (.*);

@@ tb/sv/deb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker - result predictor and scoreboard for the ring-buffer deque
// Watches the capacity, request and result channels, keeps its own deque
// image and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [deb_pkg::CNT_W-1:0]          cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [deb_pkg::OP_W-1:0]           opcode,
  input  logic [deb_pkg::DATA_WIDTH_DEF-1:0] item_value,
  input  logic [deb_pkg::CNT_W-1:0]          position,
  input  logic [deb_pkg::CNT_W-1:0]          range_end,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [deb_pkg::DATA_WIDTH_DEF-1:0] read_value,
  input  logic [deb_pkg::ST_W-1:0]           status,
  input  logic [deb_pkg::CNT_W-1:0]          element_count,
  input  logic                               is_full,
  input  logic                               is_empty,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int CW = deb_pkg::CNT_W;
  localparam int DW = deb_pkg::DATA_WIDTH_DEF;

  typedef struct packed {
    logic [DW-1:0]           rd;
    logic [deb_pkg::ST_W-1:0] st;
    logic [CW-1:0]           cnt;
    logic                    full;
    logic                    empty;
  } deque_result_t;

  logic [DW-1:0] contents[$];   // front of the deque at index 0
  deque_result_t awaited[$];
  int            cap_eff;
  int            results_seen;

  task automatic flag_mismatch(input string what);
    $display("[%0t] checker: result %0d: %s", $realtime, results_seen, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [CW-1:0] got,
                             input logic [CW-1:0] want);
    if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // an index equal to the size appends
  function automatic void put_at(input int idx, input logic [DW-1:0] v);
    contents.insert(idx, v);
  endfunction

  function automatic deque_result_t apply_request(input deb_pkg::op_t op,
                                                  input logic [DW-1:0] v,
                                                  input int pos, input int rend);
    deque_result_t r;
    int n;
    r = '0;
    r.st = deb_pkg::ST_OK;
    n = contents.size();
    case (op) inside
      deb_pkg::OP_PUSH_BACK, deb_pkg::OP_PUSH_FRONT: begin
        if (cap_eff == 0) r.st = deb_pkg::ST_ZEROCAP;
        else if (n >= cap_eff) r.st = deb_pkg::ST_FULL;
        else if (op == deb_pkg::OP_PUSH_BACK) put_at(n, v);
        else put_at(0, v);
      end
      deb_pkg::OP_POP_BACK, deb_pkg::OP_POP_FRONT: begin
        if (n == 0 || cap_eff == 0) r.st = deb_pkg::ST_EMPTY;
        else if (op == deb_pkg::OP_POP_FRONT) contents.delete(0);
        else contents.delete(n - 1);
      end
      deb_pkg::OP_READ: begin
        if (pos >= n || cap_eff == 0) r.st = deb_pkg::ST_BADIDX;
        else r.rd = contents[pos];
      end
      deb_pkg::OP_INSERT: begin
        if (cap_eff == 0) r.st = deb_pkg::ST_ZEROCAP;
        else if (pos > n) r.st = deb_pkg::ST_BADIDX;
        else if (n < cap_eff) put_at(pos, v);
        else if (pos > 0) begin
          // full: front drops out, item lands just ahead of the old entry
          contents.delete(0);
          put_at(pos - 1, v);
        end
      end
      deb_pkg::OP_ERASE: begin
        if (pos > rend || rend > n) r.st = deb_pkg::ST_BADIDX;
        else repeat (rend - pos) contents.delete(pos);
      end
      default: contents.delete();
    endcase
    n = contents.size();
    r.cnt   = CW'(n);
    r.full  = (n == cap_eff);
    r.empty = (n == 0);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t seen;
    deque_result_t want;
    int v;
    if (rst) begin
      contents.delete();
      awaited.delete();
      cap_eff      = int'(deb_pkg::CAP_RESET);
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // results first: a result at this edge belongs to an older request
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen = '{read_value, status, element_count, is_full, is_empty};
        if (awaited.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = awaited[0];
          awaited.delete(0);
          check_field("read_value", CW'(seen.rd), CW'(want.rd));
          check_field("status", CW'(seen.st), CW'(want.st));
          check_field("element_count", seen.cnt, want.cnt);
          check_field("is_full", CW'(seen.full), CW'(want.full));
          check_field("is_empty", CW'(seen.empty), CW'(want.empty));
        end
        results_seen++;
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        v = int'(cfg_data);
        cap_eff = (v > deb_pkg::DEPTH_DEF) ? deb_pkg::DEPTH_DEF : v;
        contents.delete();
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        awaited.insert(awaited.size(),
                       apply_request(deb_pkg::op_t'(opcode), item_value,
                                     int'(position), int'(range_end)));
    end
    pending = awaited.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the ring-buffer deque
// Directed corner requests, then capacity phases of weighted random requests
// with random idling on both channels; deque_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW = deb_pkg::CNT_W;
  localparam int DW = deb_pkg::DATA_WIDTH_DEF;
  localparam int LONG_HOLD = 200;  // receiver hold-off, in cycles
  localparam int SETTLE    = 20;   // quiet cycles after the last result
  localparam int NUM_PHASES = 12;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CW-1:0]            cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [deb_pkg::OP_W-1:0] opcode;
  logic [DW-1:0]            item_value;
  logic [CW-1:0]            position;
  logic [CW-1:0]            range_end;
  logic                     out_valid;
  logic                     out_stall;
  logic [DW-1:0]            read_value;
  logic [deb_pkg::ST_W-1:0] status;
  logic [CW-1:0]            element_count;
  logic                     is_full;
  logic                     is_empty;

  int mismatches;
  int awaiting;    // predictions not yet matched by a result
  bit calm;        // set for the last phase: no idling on either side
  int hold_asks;   // bumped by the sender to request a long receiver hold

  double_ended_ring_buffer u_top (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .opcode, .item_value, .position, .range_end,
    .out_valid, .out_stall, .read_value, .status, .element_count,
    .is_full, .is_empty
  );

  deque_checker u_checker (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .opcode, .item_value, .position, .range_end,
    .out_valid, .out_stall, .read_value, .status, .element_count,
    .is_full, .is_empty,
    .fail_count(mismatches),
    .pending(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every request an insert or erase that
  // moves 255 entries, the most any one can, plus worst-case gaps and stalls) is ~13 ms.
  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Result side. Random stall bursts, plus a long hold-off when asked; the
  // hold is counted here so the sender keeps offering requests meanwhile.
  initial begin : result_side
    int holds_done;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_asks) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // All request tasks start and end on a falling edge.
  task automatic send_req(input deb_pkg::op_t op, input logic [DW-1:0] v,
                          input logic [CW-1:0] pos, input logic [CW-1:0] rend);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    item_value <= v;
    position   <= pos;
    range_end  <= rend;
    // hold the payload until the block takes it
    forever begin
      @(posedge clk);
      if (in_stall === 1'b0) break;
    end
    @(negedge clk);
  endtask

  // Sender pause: no request in flight and every result back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Capacity writes only land on an idle block.
  task automatic write_capacity(input logic [CW-1:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    forever begin
      @(posedge clk);
      if (cfg_ready === 1'b1) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One weighted random request. Filling favors pushes and inserts, draining
  // favors pops and erases; a slice is pure noise across all field values.
  task automatic random_request(input bit fill, input int cap);
    deb_pkg::op_t  op;
    logic [DW-1:0] v;
    logic [CW-1:0] p;
    logic [CW-1:0] e;
    int            r;
    v = DW'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 8) begin
      op = deb_pkg::op_t'(deb_pkg::OP_W'($urandom_range(0, 7)));
      p  = CW'($urandom_range(0, 511));
      e  = CW'($urandom_range(0, 511));
    end else begin
      r = $urandom_range(0, 99);
      if (fill) begin
        if (r < 26)      op = deb_pkg::OP_PUSH_BACK;
        else if (r < 46) op = deb_pkg::OP_PUSH_FRONT;
        else if (r < 64) op = deb_pkg::OP_INSERT;
        else if (r < 78) op = deb_pkg::OP_READ;
        else if (r < 86) op = deb_pkg::OP_POP_FRONT;
        else if (r < 92) op = deb_pkg::OP_POP_BACK;
        else if (r < 98) op = deb_pkg::OP_ERASE;
        else             op = deb_pkg::OP_CLEAR;
      end else begin
        if (r < 22)      op = deb_pkg::OP_POP_FRONT;
        else if (r < 44) op = deb_pkg::OP_POP_BACK;
        else if (r < 60) op = deb_pkg::OP_ERASE;
        else if (r < 76) op = deb_pkg::OP_READ;
        else if (r < 86) op = deb_pkg::OP_PUSH_BACK;
        else if (r < 92) op = deb_pkg::OP_PUSH_FRONT;
        else if (r < 98) op = deb_pkg::OP_INSERT;
        else             op = deb_pkg::OP_CLEAR;
      end
      // indexes half the time near the front, otherwise anywhere up to one past cap
      p = $urandom_range(0, 1) ? CW'($urandom_range(0, cap + 1)) : CW'($urandom_range(0, 4));
      e = CW'(p + $urandom_range(0, 3));
      if (op == deb_pkg::OP_ERASE && p > 0 && $urandom_range(0, 9) == 0)
        e = p - 1'b1;  // reversed range
    end
    send_req(op, v, p, e);
  endtask

  initial begin : stimulus
    logic [CW-1:0] phase_caps [NUM_PHASES];
    int  cap;
    int  left;
    int  n;
    int  ph;
    bit  fill;

    phase_caps = '{9'd1, 9'd3, 9'd0, 9'd6, 9'd2, 9'd16, 9'd255, 9'd9,
                   9'd4, 9'd256, 9'd12, 9'd5};
    phase_caps[7]  = CW'($urandom_range(1, 40));
    phase_caps[10] = CW'($urandom_range(1, 40));

    calm       = 1'b0;
    hold_asks  = 0;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    opcode     = deb_pkg::OP_READ;
    item_value = '0;
    position   = '0;
    range_end  = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed: reset capacity (256) ---
    send_req(deb_pkg::OP_POP_BACK,   8'h00, 9'd0,   9'd0);    // pop of empty
    send_req(deb_pkg::OP_POP_FRONT,  8'h00, 9'd0,   9'd0);
    send_req(deb_pkg::OP_READ,       8'h00, 9'd0,   9'd0);    // read past count
    send_req(deb_pkg::OP_INSERT,     8'h77, 9'd1,   9'd0);    // insert past count
    send_req(deb_pkg::OP_INSERT,     8'hFF, 9'd0,   9'd0);
    send_req(deb_pkg::OP_PUSH_BACK,  8'h00, 9'd0,   9'd0);
    send_req(deb_pkg::OP_PUSH_FRONT, 8'hA5, 9'd0,   9'd0);
    send_req(deb_pkg::OP_READ,       8'h00, 9'd1,   9'd0);
    send_req(deb_pkg::OP_READ,       8'h00, 9'd511, 9'd511);  // far out of range
    send_req(deb_pkg::OP_INSERT,     8'h5A, 9'd1,   9'd0);
    send_req(deb_pkg::OP_ERASE,      8'h00, 9'd2,   9'd1);    // start above end
    send_req(deb_pkg::OP_ERASE,      8'h00, 9'd1,   9'd1);    // empty range
    send_req(deb_pkg::OP_ERASE,      8'h00, 9'd0,   9'd300);  // end above count
    send_req(deb_pkg::OP_ERASE,      8'h00, 9'd1,   9'd3);
    send_req(deb_pkg::OP_POP_FRONT,  8'h00, 9'd0,   9'd0);
    send_req(deb_pkg::OP_POP_BACK,   8'h00, 9'd0,   9'd0);
    send_req(deb_pkg::OP_CLEAR,      8'h00, 9'd0,   9'd0);

    // --- directed: zero capacity ---
    write_capacity(9'd0);
    send_req(deb_pkg::OP_PUSH_BACK,  8'h12, 9'd0,   9'd0);
    send_req(deb_pkg::OP_INSERT,     8'h34, 9'd0,   9'd0);
    send_req(deb_pkg::OP_POP_FRONT,  8'h00, 9'd0,   9'd0);

    // --- directed: capacity 2, insert into a full buffer ---
    write_capacity(9'd2);
    send_req(deb_pkg::OP_PUSH_BACK,  8'h11, 9'd0,   9'd0);
    send_req(deb_pkg::OP_PUSH_FRONT, 8'h22, 9'd0,   9'd0);
    send_req(deb_pkg::OP_PUSH_BACK,  8'h99, 9'd0,   9'd0);    // full, rejected
    send_req(deb_pkg::OP_INSERT,     8'h88, 9'd0,   9'd0);    // full at front: no change
    send_req(deb_pkg::OP_INSERT,     8'h33, 9'd1,   9'd0);
    send_req(deb_pkg::OP_INSERT,     8'h44, 9'd2,   9'd0);    // full at count: lands at back
    send_req(deb_pkg::OP_READ,       8'h00, 9'd0,   9'd0);

    // --- deep phase: oversize capacity saturates to 256, fill it up ---
    write_capacity(9'h1FF);
    hold_asks++;   // receiver sits still while the sender keeps pushing
    for (n = 0; n < deb_pkg::DEPTH_DEF; n++)
      send_req($urandom_range(0, 1) ? deb_pkg::OP_PUSH_BACK : deb_pkg::OP_PUSH_FRONT,
               DW'($urandom_range(0, 255)), 9'd0, 9'd0);
    for (n = 0; n < 40; n++) random_request(1'b1, deb_pkg::DEPTH_DEF);

    // --- random phases over a spread of capacities ---
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      write_capacity(phase_caps[ph]);
      cap  = (phase_caps[ph] > deb_pkg::DEPTH_DEF) ? deb_pkg::DEPTH_DEF : int'(phase_caps[ph]);
      fill = 1'b1;
      left = $urandom_range(3, 2 * cap + 6);
      if (ph == 5) hold_asks++;
      for (n = 0; n < ((cap == 0) ? 20 : 70); n++) begin
        if (ph == 3 && n == 35) wait_drained();  // sender pause mid-phase
        if (left == 0) begin
          fill = !fill;
          left = $urandom_range(3, 2 * cap + 6);
        end
        random_request(fill, cap);
        left--;
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/deb_pkg.sv
rtl/deb_addr.sv
rtl/deb_mem.sv
rtl/double_ended_ring_buffer.sv
rtl/deb_checker.sv
tb/sv/deb_checker.sv
tb/sv/tb_top.sv
